// ===== rtl/core/sss_pkg.sv =====
package sss_pkg;

   // Item kinds carried on req_tuser
   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_MOVE = 1'b1
   } action_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_STEPS_PER_REV = 1'b0,
      CSR_SPEED_RPM     = 1'b1
   } csr_index_type;

   localparam int unsigned RSP_DATA_W = 40;

   localparam logic [15:0] SPR_RESET      = 16'd200;
   localparam logic [15:0] RPM_RESET      = 16'd60;
   localparam logic [31:0] PROD_RESET     = 32'd12000;
   localparam logic [15:0] INTERVAL_RESET = 16'd12000;

   // Milliseconds in one minute.
   localparam logic [31:0] MS_PER_MIN = 32'd60000;

   // A rate product above one minute in milliseconds lets every tick step, so it is
   // clamped to this value. A zero product (speed zero) is clamped the same way, which
   // matches an interval of zero.
   localparam logic [15:0] INTERVAL_FREE = 16'd60001;

   typedef struct packed {
      logic [15:0] rev_len;   // steps per revolution, zero read as one
      logic        rpm_nz;    // speed is not zero
      logic [31:0] rate_prod; // rev_len * speed, registered
   } cfg_type;

   typedef struct packed {
      logic [3:0]  coils;
      logic [15:0] position;
      logic [15:0] remaining;
      logic        busy_res;
      logic        stepped;
      logic        rejected;
   } rsp_type;

   function automatic logic [3:0] coil_lookup(input logic [1:0] phase);
      logic [3:0] pattern;
      unique case (phase)
         2'd0: pattern = 4'b1010;
         2'd1: pattern = 4'b0110;
         2'd2: pattern = 4'b0101;
         2'd3: pattern = 4'b1001;
         default: pattern = 4'b0000;
      endcase
      return pattern;
   endfunction

endpackage

// ===== rtl/core/sss_csr.sv =====
module sss_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wen,
   input  logic                csr_addr,
   input  logic [15:0]         csr_wdata,
   output sss_pkg::cfg_type    cfg
);

   logic [15:0] spr_ff, spr_in;
   logic [15:0] rpm_ff, rpm_in;
   logic [31:0] prod_ff, prod_in;
   logic [15:0] rev_len;

   always_comb begin
      spr_in = spr_ff;
      rpm_in = rpm_ff;
      if (csr_wen && (csr_addr == sss_pkg::CSR_STEPS_PER_REV)) begin
         spr_in = csr_wdata;
      end
      if (csr_wen && (csr_addr == sss_pkg::CSR_SPEED_RPM)) begin
         rpm_in = csr_wdata;
      end
   end

   assign rev_len = (spr_ff == 16'd0) ? 16'd1 : spr_ff;

   // The step interval is floor(60000 / (rev_len * rpm)); only this product is kept,
   // the step logic compares against it instead of dividing.
   assign prod_in = 32'(rev_len) * 32'(rpm_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff  <= sss_pkg::SPR_RESET;
         rpm_ff  <= sss_pkg::RPM_RESET;
         prod_ff <= sss_pkg::PROD_RESET;
      end else begin
         spr_ff  <= spr_in;
         rpm_ff  <= rpm_in;
         prod_ff <= prod_in;
      end
   end

   assign cfg.rev_len   = rev_len;
   assign cfg.rpm_nz    = (rpm_ff != 16'd0);
   assign cfg.rate_prod = prod_ff;

endmodule

// ===== rtl/core/sss_step.sv =====
module sss_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_fire,
   input  logic                item_action,
   input  logic [15:0]         item_count,
   input  sss_pkg::cfg_type    cfg,
   output sss_pkg::rsp_type    rsp_next
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] togo_ff, togo_in;
   logic        fwd_ff, fwd_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [3:0]  coil_ff, coil_in;
   logic [15:0] interval_ff, interval_in;

   logic        idle;
   logic [15:0] elapsed_inc;
   logic [16:0] ticks_p1;
   logic [32:0] due_prod;
   logic        due;
   logic        stepped;
   logic        rejected;

   assign idle        = (togo_ff == 16'd0);
   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign ticks_p1    = {1'b0, elapsed_inc} + 17'd1;

   // elapsed >= floor(60000 / P) holds exactly when (elapsed + 1) * P > 60000.
   assign due_prod = 33'(ticks_p1) * 33'(interval_ff);
   assign due      = (due_prod > 33'(sss_pkg::MS_PER_MIN));

   always_comb begin
      pos_in      = pos_ff;
      togo_in     = togo_ff;
      fwd_in      = fwd_ff;
      elapsed_in  = elapsed_ff;
      coil_in     = coil_ff;
      interval_in = interval_ff;
      stepped     = 1'b0;
      rejected    = 1'b0;

      // The interval follows the configuration only between moves.
      if (idle) begin
         if ((cfg.rate_prod == 32'd0) || (cfg.rate_prod > sss_pkg::MS_PER_MIN)) begin
            interval_in = sss_pkg::INTERVAL_FREE;
         end else begin
            interval_in = cfg.rate_prod[15:0];
         end
      end

      unique case (item_action)
         sss_pkg::ACT_MOVE: begin
            if (!idle) begin
               rejected = 1'b1;
            end else if (item_count != 16'd0) begin
               if (item_count[15]) begin
                  fwd_in  = 1'b0;
                  togo_in = (~item_count) + 16'd1;
               end else begin
                  fwd_in  = 1'b1;
                  togo_in = item_count;
               end
            end
         end
         sss_pkg::ACT_TICK: begin
            elapsed_in = elapsed_inc;
            if (!idle && cfg.rpm_nz && due) begin
               stepped = 1'b1;
               if (fwd_ff) begin
                  if (({1'b0, pos_ff} + 17'd1) >= {1'b0, cfg.rev_len}) begin
                     pos_in = 16'd0;
                  end else begin
                     pos_in = pos_ff + 16'd1;
                  end
               end else begin
                  if ((pos_ff == 16'd0) || (pos_ff >= cfg.rev_len)) begin
                     pos_in = cfg.rev_len - 16'd1;
                  end else begin
                     pos_in = pos_ff - 16'd1;
                  end
               end
               togo_in    = togo_ff - 16'd1;
               elapsed_in = 16'd0;
               coil_in    = sss_pkg::coil_lookup(pos_in[1:0]);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 16'd0;
         togo_ff     <= 16'd0;
         fwd_ff      <= 1'b0;
         elapsed_ff  <= 16'd0;
         coil_ff     <= 4'd0;
         interval_ff <= sss_pkg::INTERVAL_RESET;
      end else if (item_fire) begin
         pos_ff      <= pos_in;
         togo_ff     <= togo_in;
         fwd_ff      <= fwd_in;
         elapsed_ff  <= elapsed_in;
         coil_ff     <= coil_in;
         interval_ff <= interval_in;
      end
   end

   assign rsp_next.coils     = coil_in;
   assign rsp_next.position  = pos_in;
   assign rsp_next.remaining = togo_in;
   assign rsp_next.busy_res  = (togo_in != 16'd0);
   assign rsp_next.stepped   = stepped;
   assign rsp_next.rejected  = rejected;

endmodule

// ===== rtl/core/stepper_step_sequencer_core.sv =====
// Four-wire stepper sequencer.
// The req channel carries one word per item: req_tuser selects a one millisecond
// tick (0) or a move command (1), and req_tdata holds the signed step count of a
// move. Every accepted word gives exactly one rsp word with the coil drive, the
// position within the revolution, the steps still to go and three status flags.
// A word accepted is held in the input register, worked on once the result register
// is free or being read, and shows on rsp_tvalid from the result register. One word
// per cycle is sustained while rsp_tready stays high; the only loop is the state
// update between the input register and the result register.
// When rsp_tready is low the result register holds its word and the input register
// can still take one more word before req_tready falls.
// The csr port writes steps per revolution and speed. Their product is registered
// from the setting registers, so a write takes effect for a move that starts once
// the product register holds it; a move already under way keeps its interval.
// Synchronous reset empties both registers, stops any move, turns all coils off and
// restores 200 steps per revolution at 60 rpm.
module stepper_step_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] move_count
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] coils, [19:4] position, [35:20] remaining, [36] busy_res,
   // [37] stepped, [38] rejected, [39] zero
   output logic [sss_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   logic             in_valid_ff, in_valid_in;
   logic             in_action_ff;
   logic [15:0]      in_count_ff;
   logic             out_valid_ff, out_valid_in;
   sss_pkg::rsp_type out_data_ff;

   sss_pkg::cfg_type cfg;
   sss_pkg::rsp_type rsp_next;
   logic             req_fire;
   logic             advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_action_ff <= req_tuser;
         in_count_ff  <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= rsp_next;
      end
   end

   sss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sss_step u_step (
      .clock       (clock),
      .reset       (reset),
      .item_fire   (advance),
      .item_action (in_action_ff),
      .item_count  (in_count_ff),
      .cfg         (cfg),
      .rsp_next    (rsp_next)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0,
                        out_data_ff.rejected,
                        out_data_ff.stepped,
                        out_data_ff.busy_res,
                        out_data_ff.remaining,
                        out_data_ff.position,
                        out_data_ff.coils};

endmodule

// ===== dv/stepper_motion_checker.sv =====
`timescale 1ns / 100ps

module stepper_motion_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [15:0]                    req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [sss_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_wen,
   input  logic                           csr_addr,
   input  logic [15:0]                    csr_wdata,
   output int unsigned                    motion_faults,
   output int unsigned                    words_owed
);

   // Laid out so that the struct lines up with the bits of rsp_tdata.
   typedef struct packed {
      logic        pad;
      logic        rejected;
      logic        stepped;
      logic        busy;
      logic [15:0] remaining;
      logic [15:0] position;
      logic [3:0]  coils;
   } motion_word_type;

   motion_word_type predicted_q[$];
   int unsigned     fault_tally;

   logic [15:0] rev_setting;
   logic [15:0] rpm_setting;
   logic [15:0] shaft_pos;
   logic [15:0] pending_steps;
   logic        going_forward;
   logic [15:0] ticks_since_step;
   logic [3:0]  coil_drive;
   logic [15:0] tick_interval;

   task automatic predict_motion(input logic act, input logic [15:0] count,
                                 output motion_word_type w);
      int unsigned rev;
      logic        stepped;
      logic        rejected;
      rev = (rev_setting == 16'd0) ? 1 : rev_setting;
      stepped = 1'b0;
      rejected = 1'b0;
      // The interval is only refreshed between moves.
      if (pending_steps == 16'd0)
         tick_interval = (rpm_setting == 16'd0) ? 16'd0 :
                         16'((60000 / rev) / rpm_setting);
      if (act == sss_pkg::ACT_MOVE) begin
         if (pending_steps != 16'd0) begin
            rejected = 1'b1;
         end else if (count != 16'd0) begin
            going_forward = !count[15];
            pending_steps = count[15] ? 16'd0 - count : count;
         end
      end else begin
         if (ticks_since_step != 16'hFFFF)
            ticks_since_step = ticks_since_step + 16'd1;
         if (pending_steps != 16'd0 && rpm_setting != 16'd0 &&
             ticks_since_step >= tick_interval) begin
            // A position left beyond a shortened revolution is pulled back inside.
            if (going_forward) begin
               if (shaft_pos + 32'd1 >= rev)
                  shaft_pos = 16'd0;
               else
                  shaft_pos = shaft_pos + 16'd1;
            end else begin
               if (shaft_pos == 16'd0 || shaft_pos >= rev)
                  shaft_pos = 16'(rev - 1);
               else
                  shaft_pos = shaft_pos - 16'd1;
            end
            pending_steps = pending_steps - 16'd1;
            ticks_since_step = 16'd0;
            case (shaft_pos[1:0])
               2'd0: coil_drive = 4'b1010;
               2'd1: coil_drive = 4'b0110;
               2'd2: coil_drive = 4'b0101;
               default: coil_drive = 4'b1001;
            endcase
            stepped = 1'b1;
         end
      end
      w.pad = 1'b0;
      w.rejected = rejected;
      w.stepped = stepped;
      w.busy = (pending_steps != 16'd0);
      w.remaining = pending_steps;
      w.position = shaft_pos;
      w.coils = coil_drive;
   endtask

   always @(posedge clock) begin : watch
      motion_word_type want;
      motion_word_type got;
      if (reset) begin
         predicted_q.delete();
         fault_tally = 0;
         rev_setting = sss_pkg::SPR_RESET;
         rpm_setting = sss_pkg::RPM_RESET;
         shaft_pos = 16'd0;
         pending_steps = 16'd0;
         going_forward = 1'b0;
         ticks_since_step = 16'd0;
         coil_drive = 4'b0000;
         tick_interval = 16'((60000 / sss_pkg::SPR_RESET) / sss_pkg::RPM_RESET);
      end else begin
         if (csr_wen) begin
            if (csr_addr == sss_pkg::CSR_STEPS_PER_REV)
               rev_setting = csr_wdata;
            else
               rpm_setting = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (predicted_q.size() == 0) begin
               fault_tally++;
               if (fault_tally <= 10)
                  $display("motion check: unexpected word %h", rsp_tdata);
            end else begin
               want = predicted_q.pop_front();
               if (got.coils !== want.coils || got.position !== want.position ||
                   got.remaining !== want.remaining || got.busy !== want.busy ||
                   got.stepped !== want.stepped || got.rejected !== want.rejected ||
                   got.pad !== want.pad) begin
                  fault_tally++;
                  if (fault_tally <= 10) begin
                     $display("exp coils %b pos %0d rem %0d busy %b stp %b rej %b",
                              want.coils, want.position, want.remaining, want.busy,
                              want.stepped, want.rejected);
                     $display("got coils %b pos %0d rem %0d busy %b stp %b rej %b pad %b",
                              got.coils, got.position, got.remaining, got.busy,
                              got.stepped, got.rejected, got.pad);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_motion(req_tuser, req_tdata, want);
            predicted_q.push_back(want);
         end
      end
      words_owed <= predicted_q.size();
      motion_faults <= fault_tally;
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned RUN_LIMIT = 1000000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'd0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [sss_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic        csr_wen = 1'b0;
   logic        csr_addr = 1'b0;
   logic [15:0] csr_wdata = 16'd0;

   int unsigned motion_faults;
   int unsigned words_owed;
   int unsigned cycle_count = 0;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_left = 0;
   logic        squeeze_now = 1'b0;
   logic        squeeze_done = 1'b0;

   stepper_step_sequencer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   stepper_motion_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wen       (csr_wen),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .motion_faults (motion_faults),
      .words_owed    (words_owed)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver stalls at random, except for one long hold-off that lets the
   // block fill up and push back on the sender.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (squeeze_now && !squeeze_done) begin
         hold_left <= 80;
         squeeze_done <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_word(input sss_pkg::action_type act, input logic [15:0] count);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= count;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_tick();
      send_word(sss_pkg::ACT_TICK, 16'($urandom));
   endtask

   task automatic apply_setting(input logic [15:0] spr, input logic [15:0] rpm);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wen <= 1'b1;
      csr_addr <= sss_pkg::CSR_STEPS_PER_REV;
      csr_wdata <= spr;
      @(posedge clock);
      csr_addr <= sss_pkg::CSR_SPEED_RPM;
      csr_wdata <= rpm;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic set_mode(input int unsigned idle, input int unsigned stall);
      idle_pct = idle;
      stall_pct <= stall;
   endtask

   // Short moves keep the motor mostly free to take new commands.
   function automatic logic [15:0] pick_move();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 5)
         return 16'd0;
      else if (roll < 55)
         return 16'($urandom_range(16, 1));
      else if (roll < 95)
         return 16'd0 - 16'($urandom_range(16, 1));
      else if (roll < 97)
         return 16'($urandom_range(300, 17));
      else
         return 16'd0 - 16'($urandom_range(300, 17));
   endfunction

   task automatic run_phase(input logic [15:0] spr, input logic [15:0] rpm,
                            input int unsigned idle, input int unsigned stall,
                            input int unsigned words);
      apply_setting(spr, rpm);
      set_mode(idle, stall);
      repeat (words) begin
         if ($urandom_range(99) < 80)
            send_tick();
         else
            send_word(sss_pkg::ACT_MOVE, pick_move());
      end
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: a tick while idle, a zero move, a move, a move while busy.
      send_tick();
      send_word(sss_pkg::ACT_MOVE, 16'd0);
      send_word(sss_pkg::ACT_MOVE, 16'd3);
      send_word(sss_pkg::ACT_MOVE, 16'hFFFF);
      repeat (6) send_tick();

      // A backwards move under a speed that would step on every tick, turned away while the earlier move is under way.
      apply_setting(16'd4, 16'hFFFF);
      send_word(sss_pkg::ACT_MOVE, 16'hFFFA);
      repeat (6) send_tick();

      // Zero speed leaves the earlier move pending until the speed rises; the new move is turned away.
      apply_setting(16'd200, 16'd0);
      send_word(sss_pkg::ACT_MOVE, 16'd2);
      repeat (2) send_tick();
      apply_setting(16'd200, 16'd60);
      repeat (2) send_tick();

      squeeze_now <= 1'b1;
      run_phase(16'd1000, 16'hFFFF, 0, 0, 60);
      run_phase(16'd3, 16'd20000, 73, 0, 60);
      run_phase(16'd0, 16'd30000, 0, 73, 60);
      run_phase(16'd500, 16'd7, 14, 14, 60);
      run_phase(16'd200, 16'd0, 0, 0, 60);
      run_phase(16'd7, 16'd2000, 73, 0, 60);
      run_phase(16'hFFFF, 16'd1, 0, 73, 60);
      run_phase(16'd200, 16'd60, 14, 14, 60);

      // The most negative count, taken or turned away depending on the motor.
      send_word(sss_pkg::ACT_MOVE, 16'h8000);
      repeat (4) send_tick();

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (motion_faults == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin : watchdog
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== stepper_step_sequencer_core.f =====
rtl/core/sss_pkg.sv
rtl/core/sss_csr.sv
rtl/core/sss_step.sv
rtl/core/stepper_step_sequencer_core.sv
dv/stepper_motion_checker.sv
dv/tb_top.sv
